### rtl/core/ps2_enc_pkg.sv
// Package for the quadrature mouse to PS/2 packet encoder.
// Types, header constants and the saturating step used by the tracker, sequencer and top.
// No dependencies.
package ps2_enc_pkg;

  localparam int unsigned CntW = 9;

  localparam logic [CntW-1:0] CNT_MAX = 9'h0FF;
  localparam logic [CntW-1:0] CNT_MIN = 9'h100;

  localparam logic [7:0] HDR_ALWAYS = 8'h08;
  localparam logic [7:0] HDR_XSIGN  = 8'h10;
  localparam logic [7:0] HDR_YSIGN  = 8'h20;
  localparam logic [7:0] BYTE_MASK  = 8'hFF;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_REPORT = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    SEL_HDR = 2'd0,
    SEL_X   = 2'd1,
    SEL_Y   = 2'd2
  } byte_sel_e;

  typedef struct packed {
    logic [7:0] hdr;
    logic [7:0] x;
    logic [7:0] y;
  } pkt_t;

  typedef struct packed {
    logic push;
    pkt_t pkt;
  } pkt_push_t;

  // one quadrature step, held at the counter limits
  function automatic logic [CntW-1:0] sat_step(logic [CntW-1:0] c, logic b_line);
    logic [CntW-1:0] r;
    r = c;
    if (b_line) begin
      if (c != CNT_MIN) r = c - CntW'(1);
    end else begin
      if (c != CNT_MAX) r = c + CntW'(1);
    end
    return r;
  endfunction

endpackage

### rtl/core/ps2_enc_if.sv
// Handshake channels of the PS/2 packet encoder: pin/report items in,
// packet bytes out. No dependencies.
interface ps2_enc_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic x_a;
  logic x_b;
  logic y_a;
  logic y_b;
  logic left_n;
  logic middle_n;
  logic right_n;

  modport source (output valid, kind, x_a, x_b, y_a, y_b, left_n, middle_n, right_n,
                  input ready);
  modport sink (input valid, kind, x_a, x_b, y_a, y_b, left_n, middle_n, right_n,
                output ready);
endinterface

interface ps2_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last;

  modport source (output valid, packet_byte, last, input ready);
  modport sink (input valid, packet_byte, last, output ready);
endinterface

### rtl/core/ps2_enc_track.sv
// Movement tracker: edge detection, saturating axis counters, button store
// and packet build. Depends on ps2_enc_pkg and ps2_enc_in_if.
module ps2_enc_track import ps2_enc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  ps2_enc_in_if.sink        in_i,
  input  logic              full_i,
  output pkt_push_t         push_o
);

  logic            prev_x_q, prev_x_d;
  logic            prev_y_q, prev_y_d;
  logic [CntW-1:0] x_cnt_q, x_cnt_d;
  logic [CntW-1:0] y_cnt_q, y_cnt_d;
  logic [2:0]      btn_q, btn_d;
  logic [2:0]      btn;
  logic            accept;
  logic [7:0]      hdr;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign btn        = {!in_i.middle_n, !in_i.right_n, !in_i.left_n};

  always_comb begin
    hdr = {5'b0, btn} | HDR_ALWAYS;
    if (x_cnt_q[CntW-1]) hdr = hdr | HDR_XSIGN;
    if (y_cnt_q[CntW-1]) hdr = hdr | HDR_YSIGN;
  end

  always_comb begin
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    x_cnt_d      = x_cnt_q;
    y_cnt_d      = y_cnt_q;
    btn_d        = btn_q;
    push_o.push  = 1'b0;
    push_o.pkt.hdr = hdr & BYTE_MASK;
    push_o.pkt.x   = x_cnt_q[7:0];
    push_o.pkt.y   = y_cnt_q[7:0];
    if (accept) begin
      unique case (kind_e'(in_i.kind))
        KIND_SAMPLE: begin
          if (!prev_x_q && in_i.x_a) x_cnt_d = sat_step(x_cnt_q, in_i.x_b);
          if (!prev_y_q && in_i.y_a) y_cnt_d = sat_step(y_cnt_q, in_i.y_b);
          prev_x_d = in_i.x_a;
          prev_y_d = in_i.y_a;
        end
        KIND_REPORT: begin
          push_o.push = (btn != btn_q) || (x_cnt_q != '0) || (y_cnt_q != '0);
          x_cnt_d     = '0;
          y_cnt_d     = '0;
          btn_d       = btn;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q <= 1'b1;
      prev_y_q <= 1'b1;
      x_cnt_q  <= '0;
      y_cnt_q  <= '0;
      btn_q    <= '0;
    end else begin
      prev_x_q <= prev_x_d;
      prev_y_q <= prev_y_d;
      x_cnt_q  <= x_cnt_d;
      y_cnt_q  <= y_cnt_d;
      btn_q    <= btn_d;
    end
  end

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_i.kind == KIND_REPORT |=> x_cnt_q == '0 && y_cnt_q == '0)
    else $error("counters not cleared after report");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.push |-> !full_i)
    else $error("packet pushed while queue full");

endmodule

### rtl/core/ps2_enc_ser.sv
// Packet queue and byte sequencer: an active packet draining byte by byte
// and one pending packet behind it. Depends on ps2_enc_pkg, ps2_enc_out_if.
module ps2_enc_ser import ps2_enc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkt_push_t         push_i,
  output logic              full_o,
  ps2_enc_out_if.source     out_o
);

  logic      act_v_q, act_v_d;
  logic      pend_v_q, pend_v_d;
  pkt_t      act_q, act_d;
  pkt_t      pend_q, pend_d;
  byte_sel_e sel_q, sel_d;
  logic      pop;
  logic      pkt_done;

  assign full_o   = pend_v_q;
  assign pop      = out_o.valid && out_o.ready;
  assign pkt_done = pop && (sel_q == SEL_Y);

  assign out_o.valid = act_v_q;
  assign out_o.last  = (sel_q == SEL_Y);

  always_comb begin
    unique case (sel_q)
      SEL_HDR: out_o.packet_byte = act_q.hdr;
      SEL_X:   out_o.packet_byte = act_q.x;
      SEL_Y:   out_o.packet_byte = act_q.y;
      default: out_o.packet_byte = act_q.hdr;
    endcase
  end

  always_comb begin
    act_v_d  = act_v_q;
    pend_v_d = pend_v_q;
    act_d    = act_q;
    pend_d   = pend_q;
    sel_d    = sel_q;
    if (pop && !pkt_done) begin
      unique case (sel_q)
        SEL_HDR: sel_d = SEL_X;
        SEL_X:   sel_d = SEL_Y;
        default: sel_d = SEL_HDR;
      endcase
    end
    if (!act_v_q || pkt_done) begin
      sel_d = SEL_HDR;
      if (pend_v_q) begin
        act_v_d  = 1'b1;
        act_d    = pend_q;
        pend_v_d = push_i.push;
        pend_d   = push_i.pkt;
      end else begin
        act_v_d = push_i.push;
        act_d   = push_i.pkt;
      end
    end else if (push_i.push) begin
      pend_v_d = 1'b1;
      pend_d   = push_i.pkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_v_q  <= 1'b0;
      pend_v_q <= 1'b0;
      sel_q    <= SEL_HDR;
    end else begin
      act_v_q  <= act_v_d;
      pend_v_q <= pend_v_d;
      sel_q    <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q  <= act_d;
    pend_q <= pend_d;
  end

  a_pend_behind_act: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> act_v_q)
    else $error("pending packet with no active packet");

  a_sel_idle_at_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !act_v_q |-> sel_q == SEL_HDR)
    else $error("byte select not at header while idle");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_done && !pend_v_q && !push_i.push |=> !act_v_q)
    else $error("queue not empty after last byte");

endmodule

### rtl/core/quadrature_mouse_to_ps2_packet_top.sv
// Channel  Dir  Items
// in_i     in   pin sample (kind 0) or report request (kind 1)
// out_o    out  PS/2 packet bytes, last set on the Y byte
//
// One input item per cycle while in_i.ready is high; a sample updates the counters in that cycle.
// A report that emits loads a three-byte packet, bytes leave one per cycle while out_o.ready is high.
// in_i.ready drops only while both packet slots are taken.
// Reset (async, active low) idles both lines high and clears counts/buttons.
// Depends on ps2_enc_pkg, ps2_enc_if, ps2_enc_track and ps2_enc_ser.
module quadrature_mouse_to_ps2_packet_top import ps2_enc_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  ps2_enc_in_if.sink    in_i,
  ps2_enc_out_if.source out_o
);

  pkt_push_t push;
  logic      full;

  ps2_enc_track u_track (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push)
  );

  ps2_enc_ser u_ser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .out_o  (out_o)
  );

endmodule
